[design/nwom_pkg.sv]
package nwom_pkg;

    // Register indexes on the configuration channel
    typedef enum logic [0:0] {
        REG_MONTH = 1'b0,
        REG_YEAR  = 1'b1
    } reg_index_t;

    // Window selector codes
    typedef enum logic [2:0] {
        MODE_FIRST  = 3'd0,
        MODE_SECOND = 3'd1,
        MODE_THIRD  = 3'd2,
        MODE_FOURTH = 3'd3,
        MODE_TEENTH = 3'd4,
        MODE_LAST   = 3'd5
    } mode_t;

    localparam int MonthW = 4;
    localparam int YearW  = 14;
    localparam int YW     = 15;   // year + 400 fits 15 bits
    localparam int CentW  = 8;    // century count, at most 167
    localparam int KW     = 7;    // year within century
    localparam int DayW   = 5;
    localparam int SumW   = 11;   // Zeller sum before the mod 7

    localparam logic [MonthW-1:0] MonthReset = 4'd1;
    localparam logic [YearW-1:0]  YearReset  = 14'd2000;
    localparam logic [YW-1:0]     YearShift  = 15'd400;

    // floor(x / 100) = (x * Recip100) >> Recip100Shift for x < 2^15
    localparam int RecipW        = 13;
    localparam int Recip100Shift = 19;
    localparam logic [RecipW-1:0] Recip100 = 13'd5243;
    localparam logic [CentW-1:0]  Hundred  = 8'd100;

    localparam logic [2:0] WeekdayNone = 3'd7;

    typedef struct packed {
        logic [2:0]        want;
        logic [2:0]        mode;
        logic [MonthW-1:0] m;
        logic [MonthW-1:0] mz;
        logic [YW-1:0]     y;
        logic [YW-1:0]     yz;
    } s1_t;

    typedef struct packed {
        logic [2:0]        want;
        logic [2:0]        mode;
        logic [MonthW-1:0] m;
        logic [MonthW-1:0] mz;
        logic [YW-1:0]     y;
        logic [YW-1:0]     yz;
        logic [CentW-1:0]  jy;
        logic [CentW-1:0]  jz;
    } s2_t;

    typedef struct packed {
        logic [2:0]       want;
        logic             none;
        logic [DayW-1:0]  start;
        logic [5:0]       mterm;
        logic [KW-1:0]    kz;
        logic [CentW-1:0] jz;
    } s3_t;

    typedef struct packed {
        logic [2:0]      want;
        logic            none;
        logic [DayW-1:0] start;
        logic [SumW-1:0] sum;
    } s4_t;

    typedef struct packed {
        logic [2:0]      want;
        logic            none;
        logic [DayW-1:0] start;
        logic [2:0]      h;
    } s5_t;

    // (13 * (mz + 1)) / 5 for the shifted month 3..14
    function automatic logic [5:0] month_term(input logic [MonthW-1:0] mz);
        logic [5:0] r;
        case (mz)
            4'd3:    r = 6'd10;
            4'd4:    r = 6'd13;
            4'd5:    r = 6'd15;
            4'd6:    r = 6'd18;
            4'd7:    r = 6'd20;
            4'd8:    r = 6'd23;
            4'd9:    r = 6'd26;
            4'd10:   r = 6'd28;
            4'd11:   r = 6'd31;
            4'd12:   r = 6'd33;
            4'd13:   r = 6'd36;
            4'd14:   r = 6'd39;
            default: r = 6'd0;
        endcase
        return r;
    endfunction

    // x mod 7 by folding octal digits (8 = 1 mod 7)
    function automatic logic [2:0] mod7(input logic [SumW-1:0] x);
        logic [4:0] s1;
        logic [3:0] s2;
        logic [3:0] r;
        s1 = {2'b00, x[2:0]} + {2'b00, x[5:3]} + {2'b00, x[8:6]} + {3'b000, x[10:9]};
        s2 = {1'b0, s1[2:0]} + {2'b00, s1[4:3]};
        r  = (s2 >= 4'd7) ? s2 - 4'd7 : s2;
        return r[2:0];
    endfunction

endpackage

[design/nwom_year.sv]
// Clamp the month, shift the year into Zeller's form and split off the century.
module nwom_year
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [2:0]                   weekday,
    input  logic [2:0]                   mode,
    input  logic [nwom_pkg::MonthW-1:0]  month,
    input  logic [nwom_pkg::YearW-1:0]   year,
    output logic                         out_valid,
    input  logic                         out_ready,
    output nwom_pkg::s2_t                out_data
);

    logic          va_reg, va_next, vb_reg, vb_next;
    logic          ready_a, ready_b;
    nwom_pkg::s1_t a_reg, a_next;
    nwom_pkg::s2_t b_reg, b_next;

    logic [nwom_pkg::YW+nwom_pkg::RecipW-1:0] prod_y, prod_z;

    assign ready_b  = !vb_reg || out_ready;
    assign ready_a  = !va_reg || ready_b;
    assign in_ready = ready_a;
    assign va_next  = ready_a ? in_valid : va_reg;
    assign vb_next  = ready_b ? va_reg : vb_reg;

    always_comb
    begin
        a_next      = '0;
        a_next.want = weekday;
        a_next.mode = mode;
        if (month == '0)
        begin
            a_next.m = 4'd1;
        end
        else if (month > 4'd12)
        begin
            a_next.m = 4'd12;
        end
        else
        begin
            a_next.m = month;
        end
        a_next.y = {1'b0, year} + nwom_pkg::YearShift;
        // January and February count as months 13 and 14 of the year before
        if (a_next.m < 4'd3)
        begin
            a_next.mz = a_next.m + 4'd12;
            a_next.yz = a_next.y - 15'd1;
        end
        else
        begin
            a_next.mz = a_next.m;
            a_next.yz = a_next.y;
        end
    end

    assign prod_y = {{nwom_pkg::RecipW{1'b0}}, a_reg.y}
                  * {{nwom_pkg::YW{1'b0}}, nwom_pkg::Recip100};
    assign prod_z = {{nwom_pkg::RecipW{1'b0}}, a_reg.yz}
                  * {{nwom_pkg::YW{1'b0}}, nwom_pkg::Recip100};

    always_comb
    begin
        b_next      = '0;
        b_next.want = a_reg.want;
        b_next.mode = a_reg.mode;
        b_next.m    = a_reg.m;
        b_next.mz   = a_reg.mz;
        b_next.y    = a_reg.y;
        b_next.yz   = a_reg.yz;
        b_next.jy   = prod_y[nwom_pkg::Recip100Shift +: nwom_pkg::CentW];
        b_next.jz   = prod_z[nwom_pkg::Recip100Shift +: nwom_pkg::CentW];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            va_reg <= va_next;
            vb_reg <= vb_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_a && in_valid)
        begin
            a_reg <= a_next;
        end
        if (ready_b && va_reg)
        begin
            b_reg <= b_next;
        end
    end

    assign out_valid = vb_reg;
    assign out_data  = b_reg;

endmodule

[design/nwom_zeller.sv]
// Pick the window start, then add up the terms of Zeller's congruence.
module nwom_zeller
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  nwom_pkg::s2_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output nwom_pkg::s4_t out_data
);

    logic          va_reg, va_next, vb_reg, vb_next;
    logic          ready_a, ready_b;
    nwom_pkg::s3_t a_reg, a_next;
    nwom_pkg::s4_t b_reg, b_next;

    logic [nwom_pkg::YW-1:0]   hy, hz;
    logic [nwom_pkg::KW-1:0]   ky;
    logic                      leap;
    logic [nwom_pkg::DayW-1:0] mlen;

    assign ready_b  = !vb_reg || out_ready;
    assign ready_a  = !va_reg || ready_b;
    assign in_ready = ready_a;
    assign va_next  = ready_a ? in_valid : va_reg;
    assign vb_next  = ready_b ? va_reg : vb_reg;

    assign hy = nwom_pkg::YW'(in_data.jy) * nwom_pkg::YW'(nwom_pkg::Hundred);
    assign hz = nwom_pkg::YW'(in_data.jz) * nwom_pkg::YW'(nwom_pkg::Hundred);
    assign ky = nwom_pkg::KW'(in_data.y - hy);

    // Divisible by 400 means a whole century count divisible by four
    assign leap = (in_data.y[1:0] == 2'b00)
               && ((ky != '0) || (in_data.jy[1:0] == 2'b00));

    always_comb
    begin
        case (in_data.m) inside
            4'd2:                     mlen = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:  mlen = 5'd30;
            default:                  mlen = 5'd31;
        endcase
    end

    always_comb
    begin
        a_next       = '0;
        a_next.want  = in_data.want;
        case (in_data.mode)
            nwom_pkg::MODE_FIRST:  a_next.start = 5'd1;
            nwom_pkg::MODE_SECOND: a_next.start = 5'd8;
            nwom_pkg::MODE_THIRD:  a_next.start = 5'd15;
            nwom_pkg::MODE_FOURTH: a_next.start = 5'd22;
            nwom_pkg::MODE_TEENTH: a_next.start = 5'd13;
            nwom_pkg::MODE_LAST:   a_next.start = mlen - 5'd6;
            default:               a_next.start = 5'd0;
        endcase
        a_next.none  = (a_next.start == '0) || (in_data.want == nwom_pkg::WeekdayNone);
        a_next.mterm = nwom_pkg::month_term(in_data.mz);
        a_next.kz    = nwom_pkg::KW'(in_data.yz - hz);
        a_next.jz    = in_data.jz;
    end

    always_comb
    begin
        b_next       = '0;
        b_next.want  = a_reg.want;
        b_next.none  = a_reg.none;
        b_next.start = a_reg.start;
        b_next.sum   = nwom_pkg::SumW'(a_reg.start)
                     + nwom_pkg::SumW'(a_reg.mterm)
                     + nwom_pkg::SumW'(a_reg.kz)
                     + nwom_pkg::SumW'(a_reg.kz[nwom_pkg::KW-1:2])
                     + nwom_pkg::SumW'(a_reg.jz[nwom_pkg::CentW-1:2])
                     + nwom_pkg::SumW'(a_reg.jz) * 11'd5;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            va_reg <= va_next;
            vb_reg <= vb_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_a && in_valid)
        begin
            a_reg <= a_next;
        end
        if (ready_b && va_reg)
        begin
            b_reg <= b_next;
        end
    end

    assign out_valid = vb_reg;
    assign out_data  = b_reg;

endmodule

[design/nwom_day.sv]
// Reduce the sum mod 7, then step from the window start to the wanted weekday.
module nwom_day
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  nwom_pkg::s4_t               in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [nwom_pkg::DayW-1:0]   day_of_month
);

    logic                      va_reg, va_next, vb_reg, vb_next;
    logic                      ready_a, ready_b;
    nwom_pkg::s5_t             a_reg, a_next;
    logic [nwom_pkg::DayW-1:0] day_reg, day_next;
    logic [3:0]                t, off;

    assign ready_b  = !vb_reg || out_ready;
    assign ready_a  = !va_reg || ready_b;
    assign in_ready = ready_a;
    assign va_next  = ready_a ? in_valid : va_reg;
    assign vb_next  = ready_b ? va_reg : vb_reg;

    always_comb
    begin
        a_next       = '0;
        a_next.want  = in_data.want;
        a_next.none  = in_data.none;
        a_next.start = in_data.start;
        a_next.h     = nwom_pkg::mod7(in_data.sum);
    end

    // Zeller gives Saturday as 0, so the offset is (want + 1 - h) mod 7
    assign t = {1'b0, a_reg.want} + 4'd8 - {1'b0, a_reg.h};

    always_comb
    begin
        if (t >= 4'd14)
        begin
            off = t - 4'd14;
        end
        else if (t >= 4'd7)
        begin
            off = t - 4'd7;
        end
        else
        begin
            off = t;
        end
        day_next = a_reg.none ? '0 : a_reg.start + nwom_pkg::DayW'(off);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            va_reg <= va_next;
            vb_reg <= vb_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_a && in_valid)
        begin
            a_reg <= a_next;
        end
        if (ready_b && va_reg)
        begin
            day_reg <= day_next;
        end
    end

    assign out_valid    = vb_reg;
    assign day_of_month = day_reg;

endmodule

[design/nth_weekday_of_month.sv]
// Channel   | Dir | Handshake              | Payload
// ----------+-----+------------------------+-------------------------------------------
// s_axis    | in  | s_axis_tvalid/tready   | tdata[2:0] weekday, [5:3] mode
// m_axis    | out | m_axis_tvalid/tready   | tdata[4:0] day_of_month
// cfg       | in  | cfg_valid/cfg_ready    | cfg_index (0 month, 1 year), cfg_data
//
// One item enters per cycle while no stage is stalled; each result passes through
// the six register stages
// (clamp, century split, window start, Zeller sum, mod 7, output register),
// the first of which loads at the accepting edge.
// Reset is asynchronous and active low: it empties the pipeline and loads
// month 1 and year 2000. Each stage holds its item while the one after it is
// full and stalled, so a stall at the output fills the empty stages first.
module nth_weekday_of_month
(
    input  logic        clk,
    input  logic        rst_n,
    // item in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [2:0] weekday, [5:3] mode, [7:6] zero
    // item out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [4:0] day_of_month, [7:5] zero
    // register writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [13:0] cfg_data
);

    logic [nwom_pkg::MonthW-1:0] month_reg, month_next;
    logic [nwom_pkg::YearW-1:0]  year_reg, year_next;
    logic                        cfg_write;

    logic                        s2_valid, s2_ready;
    nwom_pkg::s2_t               s2_data;
    logic                        s4_valid, s4_ready;
    nwom_pkg::s4_t               s4_data;
    logic [nwom_pkg::DayW-1:0]   day_of_month;

    // Always writable; the user must change them only while the pipeline is empty
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_comb
    begin
        month_next = month_reg;
        year_next  = year_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                nwom_pkg::REG_MONTH: month_next = cfg_data[nwom_pkg::MonthW-1:0];
                nwom_pkg::REG_YEAR:  year_next  = cfg_data;
                default:             month_next = month_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            month_reg <= nwom_pkg::MonthReset;
            year_reg  <= nwom_pkg::YearReset;
        end
        else
        begin
            month_reg <= month_next;
            year_reg  <= year_next;
        end
    end

    // Clamp month, shift year, divide by 100
    nwom_year u_year
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .weekday   (s_axis_tdata[2:0]),
        .mode      (s_axis_tdata[5:3]),
        .month     (month_reg),
        .year      (year_reg),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (s2_data)
    );

    // Month length, window start and the Zeller sum
    nwom_zeller u_zeller
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_data   (s2_data),
        .out_valid (s4_valid),
        .out_ready (s4_ready),
        .out_data  (s4_data)
    );

    // Weekday of the start, then the matching day; output register last
    nwom_day u_day
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s4_valid),
        .in_ready     (s4_ready),
        .in_data      (s4_data),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .day_of_month (day_of_month)
    );

    assign m_axis_tdata = {3'b000, day_of_month};

    // With no result waiting at the output, every stage must be able to advance
    a_empty_out_takes_item : assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with the output register empty");

    a_year_write_lands : assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready && (cfg_index == nwom_pkg::REG_YEAR)
        |=> year_reg == $past(cfg_data))
        else $error("year register write lost");

    a_month_write_lands : assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready && (cfg_index == nwom_pkg::REG_MONTH)
        |=> month_reg == $past(cfg_data[3:0]))
        else $error("month register write lost");

endmodule
